>>> rtl/text_console_cursor_engine_core_macros.svh
// Assertion macros shared by the text console cursor engine RTL.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_CORE_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCCE_ASSERT_NOW(name, clk_sig, rstn_sig, ante, cons, msg) \
  name: assert property (@(posedge clk_sig) disable iff (!(rstn_sig)) \
    (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCCE_ASSERT_NEXT(name, clk_sig, rstn_sig, ante, cons, msg) \
  name: assert property (@(posedge clk_sig) disable iff (!(rstn_sig)) \
    (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/tcce_pkg.sv
// Shared constants, payload types and control structs for the text console cursor engine.
package tcce_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_WIDTH  = 8;
  localparam int CELL_COUNT = ROWS * COLUMNS;

  localparam int ROW_W   = $clog2(ROWS);
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int CELL_AW = $clog2(CELL_COUNT);
  localparam int CNT_W   = $clog2(CELL_COUNT + 1);
  localparam int POS_W   = 11;

  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_FF    = 8'h0C;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] ATTR_RESET = 8'h0F;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic        command;
    logic [7:0]  character;
    logic [10:0] cell_address;
  } in_item_t;

  typedef struct packed {
    logic [10:0] cursor_position;
    logic [15:0] cell_value;
  } out_item_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             write_cell;
    logic             scroll;
    logic             clear_all;
  } step_t;

endpackage

>>> rtl/tcce_cursor_step.sv
// Cursor update for one put byte: control code decode, wrap and scroll request.
module tcce_cursor_step (
  input  logic [tcce_pkg::ROW_W-1:0] row,
  input  logic [tcce_pkg::COL_W-1:0] col,
  input  logic [7:0]                 character,
  output tcce_pkg::step_t            step
);
  import tcce_pkg::*;

  logic [COL_W:0] tab_pos;

  always_comb begin
    tab_pos = (COL_W + 1)'(((col / TAB_WIDTH) + 1) * TAB_WIDTH);
    step.row        = row;
    step.col        = col;
    step.write_cell = 1'b0;
    step.scroll     = 1'b0;
    step.clear_all  = 1'b0;
    case (character)
      CHAR_BS: begin
        if (col != '0) begin
          step.col = col - 1'b1;
        end else if (row != '0) begin
          step.row = row - 1'b1;
          step.col = COL_W'(COLUMNS - 1);
        end
      end
      CHAR_TAB: begin
        if (tab_pos < COLUMNS) begin
          step.col = tab_pos[COL_W-1:0];
        end else begin
          step.col = COL_W'(COLUMNS - 1);
        end
      end
      CHAR_LF: begin
        step.col = '0;
        if (row >= ROWS - 1) begin
          step.row    = ROW_W'(ROWS - 1);
          step.scroll = 1'b1;
        end else begin
          step.row = row + 1'b1;
        end
      end
      CHAR_FF: begin
        step.row       = '0;
        step.col       = '0;
        step.clear_all = 1'b1;
      end
      CHAR_CR: begin
        step.col = '0;
      end
      default: begin
        step.write_cell = 1'b1;
        if (col < COLUMNS - 1) begin
          step.col = col + 1'b1;
        end else begin
          step.col = '0;
          if (row >= ROWS - 1) begin
            step.row    = ROW_W'(ROWS - 1);
            step.scroll = 1'b1;
          end else begin
            step.row = row + 1'b1;
          end
        end
      end
    endcase
  end

endmodule

>>> rtl/text_console_cursor_engine_core.sv
// Top level: cell memory with a row-offset ring, command sequencer and fill sweeper.
// A read or a put without scroll passes through the EXEC and RESP states before its result strobe is registered;
// busy stays high through those states, so a new item is not taken until the sequencer is back in idle.
// A put that scrolls adds one fill pass over a row of 80 cells; a form feed adds a pass over all 2000 cells.
// After reset a clearing pass writes all 2000 cells with busy held high.
// Results cannot be stalled; the single memory port pair sets the fill sweep rate.
`include "text_console_cursor_engine_core_macros.svh"

module text_console_cursor_engine_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tcce_pkg::in_item_t  in_data,
  output logic                out_valid,
  output tcce_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);
  import tcce_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_CLEAR = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [7:0]         attr_r;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [CELL_AW-1:0] top_r, top_nxt;
  logic [CELL_AW-1:0] fill_addr_r, fill_addr_nxt;
  logic [CNT_W-1:0]   fill_left_r, fill_left_nxt;
  logic [15:0]        fill_val_r, fill_val_nxt;
  logic               resp_pend_r, resp_pend_nxt;
  logic               rd_ok_r, rd_ok_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;
  in_item_t           item_r;

  logic [15:0]        cell_mem [CELL_COUNT];
  logic [15:0]        rd_data_r;
  logic               mem_we;
  logic [CELL_AW-1:0] mem_waddr;
  logic [15:0]        mem_wdata;
  logic [CELL_AW-1:0] mem_raddr;

  step_t              step;
  logic [CELL_AW:0]   cur_lin;
  logic [CELL_AW-1:0] cur_phys;
  logic [CELL_AW:0]   top_sum;

  function automatic logic [CELL_AW-1:0] ring_wrap(input logic [CELL_AW:0] sum);
    logic [CELL_AW:0] diff;
    diff = sum - (CELL_AW + 1)'(CELL_COUNT);
    if (sum >= CELL_COUNT) begin
      ring_wrap = diff[CELL_AW-1:0];
    end else begin
      ring_wrap = sum[CELL_AW-1:0];
    end
  endfunction

  tcce_cursor_step u_step (
    .row       (row_r),
    .col       (col_r),
    .character (item_r.character),
    .step      (step)
  );

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign cur_lin   = (CELL_AW + 1)'(row_r * COLUMNS) + (CELL_AW + 1)'(col_r);
  assign cur_phys  = ring_wrap(cur_lin + (CELL_AW + 1)'(top_r));
  assign mem_raddr = ring_wrap((CELL_AW + 1)'(item_r.cell_address) + (CELL_AW + 1)'(top_r));
  assign top_sum   = (CELL_AW + 1)'(top_r) + (CELL_AW + 1)'(COLUMNS);

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    top_nxt       = top_r;
    fill_addr_nxt = fill_addr_r;
    fill_left_nxt = fill_left_r;
    fill_val_nxt  = fill_val_r;
    resp_pend_nxt = resp_pend_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = cur_phys;
    mem_wdata     = {attr_r, item_r.character};
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (item_r.command == CMD_READ) begin
          rd_ok_nxt = (item_r.cell_address < CELL_COUNT);
          state_nxt = S_RESP;
        end else begin
          rd_ok_nxt = 1'b0;
          row_nxt   = step.row;
          col_nxt   = step.col;
          mem_we    = step.write_cell;
          if (step.clear_all) begin
            fill_addr_nxt = '0;
            fill_left_nxt = CNT_W'(CELL_COUNT);
            fill_val_nxt  = {attr_r, CHAR_SPACE};
            resp_pend_nxt = 1'b1;
            state_nxt     = S_CLEAR;
          end else if (step.scroll) begin
            fill_addr_nxt = top_r;
            fill_left_nxt = CNT_W'(COLUMNS);
            fill_val_nxt  = {attr_r, CHAR_SPACE};
            resp_pend_nxt = 1'b1;
            top_nxt       = ring_wrap(top_sum);
            state_nxt     = S_CLEAR;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_CLEAR: begin
        mem_we        = 1'b1;
        mem_waddr     = fill_addr_r;
        mem_wdata     = fill_val_r;
        fill_addr_nxt = fill_addr_r + 1'b1;
        fill_left_nxt = fill_left_r - 1'b1;
        if (fill_left_r == CNT_W'(1)) begin
          state_nxt = resp_pend_r ? S_RESP : S_IDLE;
        end
      end
      S_RESP: begin
        out_valid_nxt                = 1'b1;
        out_data_nxt.cursor_position = POS_W'(cur_lin);
        out_data_nxt.cell_value      =
          ((item_r.command == CMD_READ) && rd_ok_r) ? rd_data_r : 16'h0000;
        resp_pend_nxt                = 1'b0;
        state_nxt                    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      attr_r      <= ATTR_RESET;
      row_r       <= '0;
      col_r       <= '0;
      top_r       <= '0;
      fill_addr_r <= '0;
      fill_left_r <= CNT_W'(CELL_COUNT);
      fill_val_r  <= {ATTR_RESET, CHAR_SPACE};
      resp_pend_r <= 1'b0;
      rd_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      top_r       <= top_nxt;
      fill_addr_r <= fill_addr_nxt;
      fill_left_r <= fill_left_nxt;
      fill_val_r  <= fill_val_nxt;
      resp_pend_r <= resp_pend_nxt;
      rd_ok_r     <= rd_ok_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        attr_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if ((state_r == S_IDLE) && start) begin
      item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= cell_mem[mem_raddr];
  end

  `TCCE_ASSERT_NOW(a_row_in_range, clk, rst_n, 1'b1, row_r < ROWS, "cursor row out of range")
  `TCCE_ASSERT_NOW(a_top_in_range, clk, rst_n, 1'b1, top_r < CELL_COUNT, "ring offset out of range")
  `TCCE_ASSERT_NOW(a_fill_nonzero, clk, rst_n, state_r == S_CLEAR, fill_left_r != '0, "fill count empty")
  `TCCE_ASSERT_NEXT(a_accept_exec, clk, rst_n, start && !busy, state_r == S_EXEC, "accepted transfer not executed")
  `TCCE_ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid_r, !out_valid_r, "result strobe longer than one cycle")

endmodule

>>> tb/sv/text_console_cursor_engine_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the text console cursor engine: a shadow screen predicts each result.
module text_console_cursor_engine_core_tb;
  import tcce_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASE_ITEMS    = 360;
  localparam int ADDR_TOP       = 2047;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      start     = 1'b0;
  logic      busy;
  in_item_t  in_data   = '0;
  logic      out_valid;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [7:0] cfg_data = '0;

  logic [15:0]      screen_model [CELL_COUNT];
  logic [ROW_W-1:0] cursor_row = '0;
  logic [COL_W-1:0] cursor_col = '0;
  logic [7:0]       text_attr  = ATTR_RESET;
  out_item_t        expected_results [$];
  int               mismatch_count = 0;
  int               idle_pct = 27;
  int               quiet_cycles = 0;

  text_console_cursor_engine_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    for (int i = 0; i < CELL_COUNT; i++) screen_model[i] = {ATTR_RESET, CHAR_SPACE};
  end

  function automatic void blank_cells(int first, int count);
    for (int i = first; i < first + count; i++) screen_model[i] = {text_attr, CHAR_SPACE};
  endfunction

  function automatic void advance_line();
    cursor_col = '0;
    if (cursor_row == ROWS - 1) begin
      for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
      blank_cells((ROWS - 1) * COLUMNS, COLUMNS);
    end else begin
      cursor_row++;
    end
  endfunction

  function automatic out_item_t console_step(in_item_t item);
    out_item_t res;
    int        tab_stop;
    res.cell_value = '0;
    if (item.command == CMD_PUT) begin
      case (item.character)
        CHAR_BS: begin
          if (cursor_col != 0) begin
            cursor_col--;
          end else if (cursor_row != 0) begin
            cursor_row--;
            cursor_col = COL_W'(COLUMNS - 1);
          end
        end
        CHAR_TAB: begin
          tab_stop = TAB_WIDTH * (int'(cursor_col) / TAB_WIDTH + 1);
          cursor_col = (tab_stop < COLUMNS) ? COL_W'(tab_stop) : COL_W'(COLUMNS - 1);
        end
        CHAR_LF: advance_line();
        CHAR_FF: begin
          blank_cells(0, CELL_COUNT);
          cursor_row = '0;
          cursor_col = '0;
        end
        CHAR_CR: cursor_col = '0;
        default: begin
          screen_model[cursor_row * COLUMNS + cursor_col] = {text_attr, item.character};
          if (cursor_col < COLUMNS - 1) begin
            cursor_col++;
          end else begin
            advance_line();
          end
        end
      endcase
    end else if (item.cell_address < CELL_COUNT) begin
      res.cell_value = screen_model[item.cell_address];
    end
    res.cursor_position = POS_W'(cursor_row * COLUMNS + cursor_col);
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected, actual %h", $time, out_data);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.cursor_position !== want.cursor_position) begin
            $display("%0t: cursor_position expected %0d actual %0d", $time,
                     want.cursor_position, out_data.cursor_position);
            mismatch_count++;
          end
          if (out_data.cell_value !== want.cell_value) begin
            $display("%0t: cell_value expected %h actual %h", $time,
                     want.cell_value, out_data.cell_value);
            mismatch_count++;
          end
        end
      end
      if (start && !busy) expected_results.push_back(console_step(in_data));
      if (cfg_valid && cfg_ready) text_attr = cfg_data;
    end
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_item(in_item_t item);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic put_char(logic [7:0] code);
    in_item_t item;
    item.command      = CMD_PUT;
    item.character    = code;
    item.cell_address = 11'($urandom_range(0, ADDR_TOP));
    send_item(item);
  endtask

  task automatic read_cell(int addr);
    in_item_t item;
    item.command      = CMD_READ;
    item.character    = 8'($urandom_range(0, 255));
    item.cell_address = POS_W'(addr);
    send_item(item);
  endtask

  task automatic go_idle();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_attribute(logic [7:0] value);
    go_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_control_codes();
    read_cell(0);
    read_cell(CELL_COUNT - 1);
    read_cell(CELL_COUNT);
    read_cell(ADDR_TOP);
    put_char(CHAR_BS);
    put_char(8'h00);
    put_char(8'hFF);
    put_char(CHAR_TAB);
    put_char(CHAR_TAB);
    put_char(CHAR_CR);
    put_char(CHAR_LF);
    put_char(CHAR_BS);
    put_char(CHAR_TAB);
    put_char(8'h41);
    read_cell(COLUMNS - 1);
    read_cell(0);
    read_cell(1);
    put_char(8'h7F);
    put_char(8'h80);
    put_char(CHAR_FF);
    read_cell(1);
    put_char(CHAR_SPACE);
  endtask

  task automatic test_scroll_paths();
    write_attribute(8'hFF);
    put_char(CHAR_CR);
    repeat (ROWS - 1) put_char(CHAR_LF);
    put_char(8'h58);
    put_char(CHAR_CR);
    put_char(CHAR_LF);
    read_cell((ROWS - 2) * COLUMNS);
    read_cell((ROWS - 1) * COLUMNS);
    repeat (10) put_char(CHAR_TAB);
    put_char(8'h5A);
    read_cell((ROWS - 1) * COLUMNS - 1);
    read_cell(CELL_COUNT - 1);
    read_cell(0);
  endtask

  task automatic random_item();
    int pick;
    int recent;
    pick = $urandom_range(99);
    if (pick < 25) begin
      recent = cursor_row * COLUMNS + cursor_col - 1;
      if ($urandom_range(9) == 0) begin
        read_cell($urandom_range(CELL_COUNT, ADDR_TOP));
      end else if (pick < 6) begin
        read_cell((recent < 0) ? 0 : recent);
      end else begin
        read_cell($urandom_range(0, CELL_COUNT - 1));
      end
    end else if (pick < 37) begin
      case ($urandom_range(0, 7))
        0: put_char(CHAR_BS);
        1: put_char(CHAR_TAB);
        2: put_char(CHAR_CR);
        7: put_char(($urandom_range(3) == 0) ? CHAR_FF : CHAR_LF);
        default: put_char(CHAR_LF);
      endcase
    end else begin
      put_char(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random_traffic();
    logic [7:0] attrs [4];
    attrs[0] = 8'h00;
    attrs[1] = 8'hFF;
    attrs[2] = 8'($urandom_range(0, 255));
    attrs[3] = 8'($urandom_range(0, 255));
    for (int phase = 0; phase < 4; phase++) begin
      write_attribute(attrs[phase]);
      idle_pct = (phase == 1) ? 0 : 27;
      repeat (PHASE_ITEMS) random_item();
    end
    idle_pct = 27;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_control_codes();
    test_scroll_paths();
    test_random_traffic();
    go_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
